FILE: sv/ars_pkg.sv
// Shared types and constants for the add/sub reservation station.
`timescale 1ns / 1ps
`default_nettype none
package ars_pkg;

  localparam int ENTRIES   = 3;
  localparam int TAG_LIMIT = 8;

  localparam int OPC_W = 4;
  localparam int TAG_W = 4;
  localparam int VAL_W = 32;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_ISSUE    = 2'd1,
    MODE_CAPTURE  = 2'd2,
    MODE_DISPATCH = 2'd3
  } ars_mode_t;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_WAIT    = 2'd1,
    ST_READY   = 2'd2,
    ST_RETIRED = 2'd3
  } ars_state_t;

  typedef struct packed {
    logic             issue_done;
    logic             disp_done;
    logic [OPC_W-1:0] opcode;
    logic [VAL_W-1:0] value_a;
    logic [VAL_W-1:0] value_b;
  } ars_chain_t;

  typedef struct packed {
    ars_mode_t        mode;
    logic [OPC_W-1:0] issue_opcode;
    logic [TAG_W-1:0] issue_tag_a;
    logic [VAL_W-1:0] issue_value_a;
    logic [TAG_W-1:0] issue_tag_b;
    logic [VAL_W-1:0] issue_value_b;
    logic [TAG_W-1:0] bcast_tag;
    logic [VAL_W-1:0] bcast_value;
    logic             capture_ok;
  } ars_op_t;

endpackage
`default_nettype wire

FILE: sv/ars_cell.sv
// One reservation station entry; issue and dispatch claims ripple along the chain.
`timescale 1ns / 1ps
`default_nettype none
module ars_cell (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      fire,
  input  wire ars_pkg::ars_op_t    op,
  input  wire ars_pkg::ars_chain_t chain_in,
  output ars_pkg::ars_chain_t      chain_out,
  output logic                     empty_next
);
  import ars_pkg::*;

  ars_state_t       state, state_next;
  logic [TAG_W-1:0] tag_a, tag_a_next, tag_b, tag_b_next;
  logic [OPC_W-1:0] opcode, opcode_next;
  logic [VAL_W-1:0] value_a, value_a_next, value_b, value_b_next;

  always_comb begin
    state_next   = state;
    tag_a_next   = tag_a;
    tag_b_next   = tag_b;
    opcode_next  = opcode;
    value_a_next = value_a;
    value_b_next = value_b;
    chain_out    = chain_in;
    case (op.mode)
      MODE_TICK: begin
        if (state == ST_WAIT && tag_a == '0 && tag_b == '0) begin
          state_next = ST_READY;
        end else if (state == ST_RETIRED) begin
          state_next = ST_EMPTY;
        end
      end
      MODE_ISSUE: begin
        if (!chain_in.issue_done && state == ST_EMPTY) begin
          state_next           = ST_WAIT;
          opcode_next          = op.issue_opcode;
          tag_a_next           = op.issue_tag_a;
          value_a_next         = op.issue_value_a;
          tag_b_next           = op.issue_tag_b;
          value_b_next         = op.issue_value_b;
          chain_out.issue_done = 1'b1;
        end
      end
      MODE_CAPTURE: begin
        if (op.capture_ok) begin
          if (tag_a == op.bcast_tag) begin
            tag_a_next   = '0;
            value_a_next = op.bcast_value;
          end
          if (tag_b == op.bcast_tag) begin
            tag_b_next   = '0;
            value_b_next = op.bcast_value;
          end
        end
      end
      MODE_DISPATCH: begin
        if (!chain_in.disp_done && state == ST_READY) begin
          state_next          = ST_RETIRED;
          chain_out.disp_done = 1'b1;
          chain_out.opcode    = opcode;
          chain_out.value_a   = value_a;
          chain_out.value_b   = value_b;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  assign empty_next = (state_next == ST_EMPTY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
      tag_a <= '0;
      tag_b <= '0;
    end else if (fire) begin
      state <= state_next;
      tag_a <= tag_a_next;
      tag_b <= tag_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      opcode  <= opcode_next;
      value_a <= value_a_next;
      value_b <= value_b_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/addsub_reservation_station.sv
// Top level of the add/sub reservation station: a chain of entry cells and an output register.
// The result of each accepted item is held in the output register until taken.
// One item per cycle unless m_tready stalls; issue/dispatch claims ripple along the chain.
// The output register frees on take, so a new item enters while the last result is taken.
// Reset: synchronous, active high; all entries empty with tags cleared, output empty.
`timescale 1ns / 1ps
`default_nettype none
module addsub_reservation_station (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // opcode[3:0], tag_a[7:4], value_a[39:8], tag_b[43:40], value_b[75:44],
  // bcast_tag[79:76], bcast_value[111:80]
  input  wire  [ars_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode[1:0]
  input  wire  [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // out_opcode[3:0], out_value_a[35:4], out_value_b[67:36], has_free[68], zero[71:69]
  output logic [ars_pkg::OUT_DATA_W-1:0]    m_tdata,
  // accepted[0]
  output logic                              m_tuser
);
  import ars_pkg::*;

  logic               fire;
  ars_op_t            op;
  ars_chain_t         chain [ENTRIES+1];
  logic [ENTRIES-1:0] empty_vec;
  logic               accepted_next;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  always_comb begin
    op.mode          = ars_mode_t'(s_tuser);
    op.issue_opcode  = s_tdata[3:0];
    op.issue_tag_a   = s_tdata[7:4];
    op.issue_value_a = s_tdata[39:8];
    op.issue_tag_b   = s_tdata[43:40];
    op.issue_value_b = s_tdata[75:44];
    op.bcast_tag     = s_tdata[79:76];
    op.bcast_value   = s_tdata[111:80];
    op.capture_ok    = (op.bcast_tag != '0) && (int'(op.bcast_tag) <= TAG_LIMIT);
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ars_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .fire       (fire),
      .op         (op),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .empty_next (empty_vec[i])
    );
  end

  always_comb begin
    case (op.mode)
      MODE_ISSUE:    accepted_next = chain[ENTRIES].issue_done;
      MODE_DISPATCH: accepted_next = chain[ENTRIES].disp_done;
      default:       accepted_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser <= accepted_next;
      m_tdata <= {3'b000, |empty_vec, chain[ENTRIES].value_b,
                  chain[ENTRIES].value_a, chain[ENTRIES].opcode};
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for addsub_reservation_station: directed table, then random items against a predictor.
`timescale 1ns / 1ps
module tb;
  import ars_pkg::*;

  localparam int RAND_ITEMS  = 500;
  localparam int QUIET_ITEMS = 60;
  localparam int WILD_ITEMS  = 20;

  typedef struct packed {
    ars_mode_t        mode;
    logic [OPC_W-1:0] opcode;
    logic [TAG_W-1:0] tag_a;
    logic [VAL_W-1:0] value_a;
    logic [TAG_W-1:0] tag_b;
    logic [VAL_W-1:0] value_b;
    logic [TAG_W-1:0] bcast_tag;
    logic [VAL_W-1:0] bcast_value;
  } rs_item_t;

  typedef struct packed {
    logic             accepted;
    logic [OPC_W-1:0] opcode;
    logic [VAL_W-1:0] value_a;
    logic [VAL_W-1:0] value_b;
    logic             has_free;
  } rs_result_t;

  typedef struct packed {
    rs_item_t   item;
    logic       typed;
    rs_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  wire s_tready;
  wire m_tvalid;
  wire [OUT_DATA_W-1:0] m_tdata;
  wire m_tuser;

  ars_state_t       slot_state [ENTRIES];
  logic [OPC_W-1:0] slot_opcode [ENTRIES];
  logic [TAG_W-1:0] slot_tag_a [ENTRIES];
  logic [VAL_W-1:0] slot_value_a [ENTRIES];
  logic [TAG_W-1:0] slot_tag_b [ENTRIES];
  logic [VAL_W-1:0] slot_value_b [ENTRIES];

  rs_result_t pending_q [$];
  dir_row_t   dir_tab [$];
  int         errors = 0;
  bit         idle_on = 1'b1;
  int         stall_left = 0;

  addsub_reservation_station dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic rs_result_t station_step(rs_item_t it);
    rs_result_t r;
    bit         done;
    r = '0;
    done = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_state[i] == ST_WAIT && slot_tag_a[i] == '0 && slot_tag_b[i] == '0) begin
            slot_state[i] = ST_READY;
          end else if (slot_state[i] == ST_RETIRED) begin
            slot_state[i] = ST_EMPTY;
          end
        end
      end
      MODE_ISSUE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && slot_state[i] == ST_EMPTY) begin
            slot_opcode[i]  = it.opcode;
            slot_tag_a[i]   = it.tag_a;
            slot_value_a[i] = it.value_a;
            slot_tag_b[i]   = it.tag_b;
            slot_value_b[i] = it.value_b;
            slot_state[i]   = ST_WAIT;
            done = 1'b1;
          end
        end
      end
      MODE_CAPTURE: begin
        if (it.bcast_tag != '0 && it.bcast_tag <= TAG_LIMIT) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_tag_a[i] == it.bcast_tag) begin
              slot_value_a[i] = it.bcast_value;
              slot_tag_a[i]   = '0;
            end
            if (slot_tag_b[i] == it.bcast_tag) begin
              slot_value_b[i] = it.bcast_value;
              slot_tag_b[i]   = '0;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && slot_state[i] == ST_READY) begin
            r.opcode  = slot_opcode[i];
            r.value_a = slot_value_a[i];
            r.value_b = slot_value_b[i];
            slot_state[i] = ST_RETIRED;
            done = 1'b1;
          end
        end
      end
    endcase
    r.accepted = done;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_state[i] == ST_EMPTY) begin
        r.has_free = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic rs_item_t random_item(bit wild);
    rs_item_t it;
    int       pick;
    it.opcode      = OPC_W'($urandom);
    it.value_a     = $urandom;
    it.value_b     = $urandom;
    it.bcast_value = $urandom;
    it.tag_a       = TAG_W'($urandom);
    it.tag_b       = TAG_W'($urandom);
    it.bcast_tag   = TAG_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      it.mode = MODE_ISSUE;
      if (wild) begin
        it.tag_a = TAG_W'($urandom_range(0, 15));
        it.tag_b = TAG_W'($urandom_range(0, 15));
      end else begin
        it.tag_a = TAG_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, TAG_LIMIT));
        it.tag_b = TAG_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, TAG_LIMIT));
      end
    end else if (pick < 6) begin
      it.mode = MODE_CAPTURE;
      it.bcast_tag = TAG_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, TAG_LIMIT));
    end else if (pick < 8) begin
      it.mode = MODE_TICK;
    end else begin
      it.mode = MODE_DISPATCH;
    end
    return it;
  endfunction

  task automatic add_row(ars_mode_t mode, logic [3:0] opc, logic [3:0] ta, logic [31:0] va,
                         logic [3:0] tb_, logic [31:0] vb, logic [3:0] btag, logic [31:0] bval,
                         logic typed, logic acc, logic [3:0] eopc, logic [31:0] eva,
                         logic [31:0] evb, logic efree);
    dir_row_t row;
    row.item = '{mode, opc, ta, va, tb_, vb, btag, bval};
    row.typed = typed;
    row.res = '{acc, eopc, eva, evb, efree};
    dir_tab.push_back(row);
  endtask

  task automatic send_item(rs_item_t it, logic typed, rs_result_t typed_res);
    rs_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {it.bcast_value, it.bcast_tag, it.value_b, it.tag_b,
                 it.value_a, it.tag_a, it.opcode};
    do @(posedge clk); while (!s_tready);
    predicted = station_step(it);
    pending_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic check_result();
    rs_result_t want;
    rs_result_t got;
    got.accepted = m_tuser;
    got.opcode   = m_tdata[3:0];
    got.value_a  = m_tdata[35:4];
    got.value_b  = m_tdata[67:36];
    got.has_free = m_tdata[68];
    if (pending_q.size() == 0) begin
      $error("unexpected item: no result pending");
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
      errors++;
    end
    if (got.opcode !== want.opcode) begin
      $error("out_opcode: expected %0h, got %0h", want.opcode, got.opcode);
      errors++;
    end
    if (got.value_a !== want.value_a) begin
      $error("out_value_a: expected %08h, got %08h", want.value_a, got.value_a);
      errors++;
    end
    if (got.value_b !== want.value_b) begin
      $error("out_value_b: expected %08h, got %08h", want.value_b, got.value_b);
      errors++;
    end
    if (got.has_free !== want.has_free) begin
      $error("has_free: expected %0d, got %0d", want.has_free, got.has_free);
      errors++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        check_result();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_state[i]   = ST_EMPTY;
      slot_opcode[i]  = '0;
      slot_tag_a[i]   = '0;
      slot_value_a[i] = '0;
      slot_tag_b[i]   = '0;
      slot_value_b[i] = '0;
    end

    add_row(MODE_TICK,     0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(MODE_CAPTURE,  0, 0, 0, 0, 0, 0, 32'hffffffff, 1, 0, 0, 0, 0, 1);
    add_row(MODE_ISSUE, 4'hf, 0, 32'h7fffffff, 0, 32'h80000000, 0, 0, 1, 1, 0, 0, 0, 1);
    add_row(MODE_ISSUE, 4'h0, 8, 32'h0, 3, 32'hffffffff, 0, 0, 1, 1, 0, 0, 0, 1);
    add_row(MODE_ISSUE, 4'h9, 3, 32'h12345678, 8, 32'h0, 0, 0, 1, 1, 0, 0, 0, 0);
    add_row(MODE_ISSUE, 4'h6, 0, 32'h1, 0, 32'h2, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(MODE_CAPTURE,  0, 0, 0, 0, 0, 8, 32'hdeadbeef, 1, 0, 0, 0, 0, 0);
    add_row(MODE_CAPTURE,  0, 0, 0, 0, 0, 9, 32'h0, 1, 0, 0, 0, 0, 0);
    add_row(MODE_CAPTURE,  0, 0, 0, 0, 0, 15, 32'h5, 1, 0, 0, 0, 0, 0);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(MODE_CAPTURE,  0, 0, 0, 0, 0, 3, 32'h80000000, 1, 0, 0, 0, 0, 0);
    add_row(MODE_TICK,     0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 1, 1, 4'hf, 32'h7fffffff, 32'h80000000, 0);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 1, 1, 4'h0, 32'hdeadbeef, 32'h80000000, 0);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 1, 1, 4'h9, 32'h80000000, 32'hdeadbeef, 0);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(MODE_TICK,     0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(MODE_ISSUE, 4'ha, 1, 32'h0, 1, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_ISSUE, 4'h3, 2, 32'h0, 0, 32'h55, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_CAPTURE,  0, 0, 0, 0, 0, 1, 32'h0f0f0f0f, 0, 0, 0, 0, 0, 0);
    add_row(MODE_TICK,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_CAPTURE,  0, 0, 0, 0, 0, 2, 32'hffffffff, 0, 0, 0, 0, 0, 0);
    add_row(MODE_TICK,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].res);
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_ITEMS) begin
        idle_on = 1'b0;
      end
      send_item(random_item(n >= RAND_ITEMS - WILD_ITEMS), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ars_pkg.sv
sv/ars_cell.sv
sv/addsub_reservation_station.sv
sim/tb.sv
